// File: rtl/lkat_pkg.sv
package lkat_pkg;

    localparam int CORDIC_STAGES   = 18;
    localparam int ANGLE_FRAC_BITS = 15;
    localparam int TABLE_LEN       = 24;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int NW        = 41;
    localparam int SW        = 6;
    localparam int NORM_STEPS = 6;
    localparam int CW        = 46;
    localparam int XW        = CW - 2;
    localparam int ZW        = 33;
    localparam int AW        = 31;
    localparam int UW        = 34;
    localparam int PW        = XW + 20;
    localparam int STAGE_W   = 5;
    localparam int YAW_W     = 19;
    localparam int PITCH_W   = 17;
    localparam int RND_SH    = 30 - ANGLE_FRAC_BITS;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FOCUS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCUS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCUS_Z = 2'd2;

    localparam logic [UW-1:0] PI_Q30       = 34'd3373259426;
    localparam logic [UW-1:0] HALF_PI_Q30  = 34'd1686629713;
    localparam logic [19:0]   INV_GAIN_Q20 = 20'd636750;
    localparam logic [UW-1:0] RND_HALF     = UW'(2 ** (RND_SH - 1));

    localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    // Round half up from Q30 radians to the output angle scale.
    function automatic logic [YAW_W-1:0] lkat_round(input logic [UW-1:0] u);
        logic [UW-1:0] sum;
        logic [UW-1:0] shifted;
        sum     = u + RND_HALF;
        shifted = sum >> RND_SH;
        return shifted[YAW_W-1:0];
    endfunction

    // Clamp a first-quadrant angle to the range zero to half pi.
    function automatic logic [AW-1:0] lkat_sat(input logic signed [ZW-1:0] z);
        logic [AW-1:0] res;
        if (z[ZW-1])
        begin
            res = '0;
        end
        else if ($unsigned(z) > ZW'(HALF_PI_Q30))
        begin
            res = AW'(HALF_PI_Q30);
        end
        else
        begin
            res = z[AW-1:0];
        end
        return res;
    endfunction

    localparam logic [YAW_W-1:0] HP_RND = lkat_round(HALF_PI_Q30);

    typedef struct packed {
        logic dx_neg;
        logic dy_pos;
        logic dy_neg;
        logic dz_pos;
        logic dz_neg;
        logic flat;
    } lkat_flags_t;

    typedef struct packed {
        lkat_flags_t              flags;
        logic [NW-1:0]            ay;
        logic [SW-1:0]            sdiff;
        logic signed [YAW_W-1:0]  yaw;
    } lkat_side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        lkat_side_t           side;
    } lkat_cordic_t;

    typedef struct packed {
        logic [NW-1:0] mh;
        logic [NW-1:0] m3;
        logic [NW-1:0] ax;
        logic [NW-1:0] ay;
        logic [NW-1:0] az;
        logic [SW-1:0] s1;
        logic [SW-1:0] s3;
        lkat_flags_t   flags;
    } lkat_norm_t;

endpackage

// File: rtl/lkat_cam_if.sv
interface lkat_cam_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;

    modport source (output valid, output cam_x, output cam_y, output cam_z, input ready);
    modport sink (input valid, input cam_x, input cam_y, input cam_z, output ready);
endinterface

// File: rtl/lkat_angle_if.sv
interface lkat_angle_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] yaw;
    logic signed [16:0] pitch;
    logic               degenerate;

    modport source (output valid, output yaw, output pitch, output degenerate, input ready);
    modport sink (input valid, input yaw, input pitch, input degenerate, output ready);
endinterface

// File: rtl/lkat_norm_cell.sv
module lkat_norm_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [lkat_pkg::SW-1:0]   shamt,
    input  logic                      prev_valid,
    input  lkat_pkg::lkat_norm_t      prev,
    output logic                      cur_valid,
    output lkat_pkg::lkat_norm_t      cur
);
    import lkat_pkg::*;

    localparam logic [NW-1:0] ONES = '1;

    logic          valid_reg;
    lkat_norm_t    data_reg;
    lkat_norm_t    data_next;
    logic [NW-1:0] hi_mask;
    logic          sh1;
    logic          sh3;

    always_comb
    begin
        hi_mask   = ~(ONES >> shamt);
        sh1       = (prev.mh & hi_mask) == '0;
        sh3       = (prev.m3 & hi_mask) == '0;
        data_next = prev;
        if (sh1)
        begin
            data_next.mh = prev.mh << shamt;
            data_next.ax = prev.ax << shamt;
            data_next.az = prev.az << shamt;
            data_next.s1 = prev.s1 + shamt;
        end
        if (sh3)
        begin
            data_next.m3 = prev.m3 << shamt;
            data_next.ay = prev.ay << shamt;
            data_next.s3 = prev.s3 + shamt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign cur_valid = valid_reg;
    assign cur       = data_reg;

endmodule

// File: rtl/lkat_cordic_cell.sv
module lkat_cordic_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [lkat_pkg::STAGE_W-1:0] stage,
    input  logic                         prev_valid,
    input  lkat_pkg::lkat_cordic_t       prev,
    output logic                         cur_valid,
    output lkat_pkg::lkat_cordic_t       cur
);
    import lkat_pkg::*;

    logic                 valid_reg;
    lkat_cordic_t         data_reg;
    lkat_cordic_t         data_next;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] step_angle;

    always_comb
    begin
        x_in       = prev.x;
        y_in       = prev.y;
        xs         = x_in >>> stage;
        ys         = y_in >>> stage;
        step_angle = $signed({{(ZW - 30){1'b0}}, ATAN_Q30[stage]});
        data_next  = prev;
        if (!y_in[CW-1])
        begin
            data_next.x = x_in + ys;
            data_next.y = y_in - xs;
            data_next.z = prev.z + step_angle;
        end
        else
        begin
            data_next.x = x_in - ys;
            data_next.y = y_in + xs;
            data_next.z = prev.z - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign cur_valid = valid_reg;
    assign cur       = data_reg;

endmodule

// File: rtl/look_at_yaw_pitch.sv
// Aim angles from a camera position toward a configured focus point. Each transaction on cam
// carries one Q16.16 position; one transaction follows on angles with yaw and pitch in radians
// scaled by 2^15 and a degenerate flag that is set, with pitch zero, when the camera sits on the
// focus point. The block takes one position per clock cycle while the output buffer has room; each
// position passes through the subtract, magnitude and six normalizing cells ahead of two rows of
// unrolled CORDIC vectoring cells, one row for yaw and one for pitch, with a gain-correction
// multiply between them. A stalled consumer stops the pipeline only after a two-entry output
// buffer fills. Write the focus registers only while no transaction is in flight.
module look_at_yaw_pitch (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lkat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lkat_pkg::CFG_W-1:0]     cfg_data,
    lkat_cam_if.sink                       cam,
    lkat_angle_if.source                   angles
);
    import lkat_pkg::*;

    logic signed [COORD_W-1:0] focus_x_reg;
    logic signed [COORD_W-1:0] focus_y_reg;
    logic signed [COORD_W-1:0] focus_z_reg;

    logic                      adv;

    logic                      d_valid_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic signed [DIFF_W-1:0]  dz_reg;

    logic                      a_valid_reg;
    logic [DIFF_W-1:0]         ax_reg;
    logic [DIFF_W-1:0]         ay_reg;
    logic [DIFF_W-1:0]         az_reg;
    lkat_flags_t               a_flags_reg;
    lkat_flags_t               a_flags_next;

    logic                      n0_valid_reg;
    lkat_norm_t                n0_reg;
    lkat_norm_t                n0_next;
    logic                      norm_valid [NORM_STEPS+1];
    lkat_norm_t                norm [NORM_STEPS+1];

    logic                      c0_valid_reg;
    lkat_cordic_t              c0_reg;
    lkat_cordic_t              c0_next;
    logic                      yaw_valid [CORDIC_STAGES+1];
    lkat_cordic_t              yaw_cell [CORDIC_STAGES+1];

    logic                      y1_valid_reg;
    logic [AW-1:0]             y1_a_reg;
    logic [AW-1:0]             y1_a_next;
    logic [PW-1:0]             y1_prod_reg;
    logic [PW-1:0]             y1_prod_next;
    lkat_side_t                y1_side_reg;
    logic [XW-1:0]             x1;

    logic                      p0_valid_reg;
    lkat_cordic_t              p0_reg;
    lkat_cordic_t              p0_next;
    logic                      pitch_valid [CORDIC_STAGES+1];
    lkat_cordic_t              pitch_cell [CORDIC_STAGES+1];
    logic [PW-1:0]             r_full;
    logic [YAW_W-1:0]          ra;
    logic [YAW_W-1:0]          rp;
    logic [YAW_W-1:0]          rm;
    logic signed [YAW_W-1:0]   yaw_sel;

    logic [AW-1:0]             b_sat;
    logic [YAW_W-1:0]          rb;
    logic signed [PITCH_W-1:0] rb_s;
    logic signed [YAW_W-1:0]   fin_yaw;
    logic signed [PITCH_W-1:0] fin_pitch;
    logic                      fin_degen;
    logic                      last_valid;
    logic                      out_load;

    logic                      out_valid_reg;
    logic signed [YAW_W-1:0]   out_yaw_reg;
    logic signed [PITCH_W-1:0] out_pitch_reg;
    logic                      out_degen_reg;
    logic                      skid_valid_reg;
    logic signed [YAW_W-1:0]   skid_yaw_reg;
    logic signed [PITCH_W-1:0] skid_pitch_reg;
    logic                      skid_degen_reg;

    // Configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_x_reg <= '0;
            focus_y_reg <= '0;
            focus_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOCUS_X: focus_x_reg <= $signed(cfg_data);
                REG_FOCUS_Y: focus_y_reg <= $signed(cfg_data);
                REG_FOCUS_Z: focus_z_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the output buffer has room.
    assign adv       = !skid_valid_reg;
    assign cam.ready = adv;

    // Differences.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            n0_valid_reg <= 1'b0;
            c0_valid_reg <= 1'b0;
            y1_valid_reg <= 1'b0;
            p0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg  <= cam.valid;
            a_valid_reg  <= d_valid_reg;
            n0_valid_reg <= a_valid_reg;
            c0_valid_reg <= norm_valid[NORM_STEPS];
            y1_valid_reg <= yaw_valid[CORDIC_STAGES];
            p0_valid_reg <= y1_valid_reg;
        end
    end

    always_comb
    begin
        a_flags_next.dx_neg = dx_reg[DIFF_W-1];
        a_flags_next.dy_pos = !dy_reg[DIFF_W-1] && (dy_reg != '0);
        a_flags_next.dy_neg = dy_reg[DIFF_W-1];
        a_flags_next.dz_pos = !dz_reg[DIFF_W-1] && (dz_reg != '0);
        a_flags_next.dz_neg = dz_reg[DIFF_W-1];
        a_flags_next.flat   = (dx_reg == '0) && (dz_reg == '0);
    end

    always_comb
    begin
        n0_next.ax    = NW'(ax_reg);
        n0_next.ay    = NW'(ay_reg);
        n0_next.az    = NW'(az_reg);
        n0_next.mh    = (ax_reg > az_reg) ? NW'(ax_reg) : NW'(az_reg);
        if ((ax_reg > az_reg) && (ax_reg > ay_reg))
        begin
            n0_next.m3 = NW'(ax_reg);
        end
        else if (az_reg > ay_reg)
        begin
            n0_next.m3 = NW'(az_reg);
        end
        else
        begin
            n0_next.m3 = NW'(ay_reg);
        end
        n0_next.s1    = '0;
        n0_next.s3    = '0;
        n0_next.flags = a_flags_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg      <= DIFF_W'(cam.cam_x) - DIFF_W'(focus_x_reg);
            dy_reg      <= DIFF_W'(cam.cam_y) - DIFF_W'(focus_y_reg);
            dz_reg      <= DIFF_W'(cam.cam_z) - DIFF_W'(focus_z_reg);
            ax_reg      <= dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
            ay_reg      <= dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
            az_reg      <= dz_reg[DIFF_W-1] ? DIFF_W'(-dz_reg) : DIFF_W'(dz_reg);
            a_flags_reg <= a_flags_next;
            n0_reg      <= n0_next;
            c0_reg      <= c0_next;
            y1_a_reg    <= y1_a_next;
            y1_prod_reg <= y1_prod_next;
            y1_side_reg <= yaw_cell[CORDIC_STAGES].side;
            p0_reg      <= p0_next;
        end
    end

    // Normalizing cells: both the horizontal pair and the full triple get their top bit at 40.
    assign norm_valid[0] = n0_valid_reg;
    assign norm[0]       = n0_reg;

    genvar k;
    generate
        for (k = 0; k < NORM_STEPS; k++)
        begin : g_norm
            lkat_norm_cell u_norm (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (adv),
                .shamt      (SW'(32 >> k)),
                .prev_valid (norm_valid[k]),
                .prev       (norm[k]),
                .cur_valid  (norm_valid[k+1]),
                .cur        (norm[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        c0_next.x          = $signed(CW'(norm[NORM_STEPS].az));
        c0_next.y          = $signed(CW'(norm[NORM_STEPS].ax));
        c0_next.z          = '0;
        c0_next.side.flags = norm[NORM_STEPS].flags;
        c0_next.side.ay    = norm[NORM_STEPS].ay;
        c0_next.side.sdiff = norm[NORM_STEPS].s1 - norm[NORM_STEPS].s3;
        c0_next.side.yaw   = '0;
    end

    // Yaw row.
    assign yaw_valid[0] = c0_valid_reg;
    assign yaw_cell[0]  = c0_reg;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_yaw
            lkat_cordic_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (adv),
                .stage      (STAGE_W'(i)),
                .prev_valid (yaw_valid[i]),
                .prev       (yaw_cell[i]),
                .cur_valid  (yaw_valid[i+1]),
                .cur        (yaw_cell[i+1])
            );
        end
    endgenerate

    // Yaw angle clamp and gain correction of the horizontal length.
    always_comb
    begin
        x1           = yaw_cell[CORDIC_STAGES].x[CW-1] ? '0 : yaw_cell[CORDIC_STAGES].x[XW-1:0];
        y1_a_next    = lkat_sat(yaw_cell[CORDIC_STAGES].z);
        y1_prod_next = PW'(x1) * PW'(INV_GAIN_Q20);
    end

    always_comb
    begin
        r_full = y1_prod_reg >> (7'd20 + 7'(y1_side_reg.sdiff));
        ra     = lkat_round(UW'(y1_a_reg));
        rp     = lkat_round(PI_Q30 + UW'(y1_a_reg));
        rm     = lkat_round(PI_Q30 - UW'(y1_a_reg));
        if (y1_side_reg.flags.flat)
        begin
            yaw_sel = -$signed(HP_RND);
        end
        else if (y1_side_reg.flags.dz_pos)
        begin
            yaw_sel = y1_side_reg.flags.dx_neg ? $signed(ra) : -$signed(ra);
        end
        else if (y1_side_reg.flags.dz_neg)
        begin
            yaw_sel = y1_side_reg.flags.dx_neg ? $signed(rm) : $signed(rp);
        end
        else
        begin
            yaw_sel = y1_side_reg.flags.dx_neg ? $signed(HP_RND) : -$signed(HP_RND);
        end
        p0_next.x        = $signed({1'b0, r_full[CW-2:0]});
        p0_next.y        = $signed(CW'(y1_side_reg.ay));
        p0_next.z        = '0;
        p0_next.side     = y1_side_reg;
        p0_next.side.yaw = yaw_sel;
    end

    // Pitch row.
    assign pitch_valid[0] = p0_valid_reg;
    assign pitch_cell[0]  = p0_reg;

    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_pitch
            lkat_cordic_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (adv),
                .stage      (STAGE_W'(i)),
                .prev_valid (pitch_valid[i]),
                .prev       (pitch_cell[i]),
                .cur_valid  (pitch_valid[i+1]),
                .cur        (pitch_cell[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        b_sat   = lkat_sat(pitch_cell[CORDIC_STAGES].z);
        rb      = lkat_round(UW'(b_sat));
        rb_s    = $signed(rb[PITCH_W-1:0]);
        fin_yaw = pitch_cell[CORDIC_STAGES].side.yaw;
        if (pitch_cell[CORDIC_STAGES].side.flags.flat)
        begin
            fin_degen = !pitch_cell[CORDIC_STAGES].side.flags.dy_pos
                        && !pitch_cell[CORDIC_STAGES].side.flags.dy_neg;
            if (pitch_cell[CORDIC_STAGES].side.flags.dy_pos)
            begin
                fin_pitch = -$signed(HP_RND[PITCH_W-1:0]);
            end
            else if (pitch_cell[CORDIC_STAGES].side.flags.dy_neg)
            begin
                fin_pitch = $signed(HP_RND[PITCH_W-1:0]);
            end
            else
            begin
                fin_pitch = '0;
            end
        end
        else
        begin
            fin_degen = 1'b0;
            fin_pitch = pitch_cell[CORDIC_STAGES].side.flags.dy_neg ? rb_s : -rb_s;
        end
    end

    // Output register with a skid entry behind it.
    assign last_valid = pitch_valid[CORDIC_STAGES];
    assign out_load   = adv && last_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (angles.ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_load;
            end
        end
        else if (out_load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (angles.ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_yaw_reg   <= skid_yaw_reg;
                out_pitch_reg <= skid_pitch_reg;
                out_degen_reg <= skid_degen_reg;
            end
            else
            begin
                out_yaw_reg   <= fin_yaw;
                out_pitch_reg <= fin_pitch;
                out_degen_reg <= fin_degen;
            end
        end
        else if (out_load)
        begin
            skid_yaw_reg   <= fin_yaw;
            skid_pitch_reg <= fin_pitch;
            skid_degen_reg <= fin_degen;
        end
    end

    assign angles.valid      = out_valid_reg;
    assign angles.yaw        = out_yaw_reg;
    assign angles.pitch      = out_pitch_reg;
    assign angles.degenerate = out_degen_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a transaction while the output register is empty");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !angles.ready && last_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("finished transaction not caught by the skid entry");

    a_degenerate_values: assert property (@(posedge clk) disable iff (!rst_n)
        (angles.valid && angles.degenerate)
        |-> (angles.pitch == '0 && angles.yaw == -$signed(HP_RND)))
        else $error("degenerate result with nonzero pitch or wrong yaw");

endmodule
